>>> design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define KTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// plain condition checked at every rising clock edge outside reset
`define KTI_ASSERT_HOLD(name, cond, msg) \
  `KTI_ASSERT(name, (cond), msg)

`endif

>>> design/kti_pkg.sv
// package: sizes, action and status codes, cell control word for the keyed table
package kti_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;

  localparam int ACTION_W = 3;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_EDIT   = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic                  go;
    action_e               action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
  } cell_ctrl_t;

endpackage

>>> design/kti_if.sv
// request and response channel interfaces of the keyed table
interface kti_req_if;
  import kti_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, output action, output key, output value, input ready);
  modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface kti_rsp_if;
  import kti_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  value_out;
  logic [COUNT_W-1:0]  entry_count;
  logic                is_empty;

  modport source (output valid, output status, output value_out, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  input is_empty, output ready);
endinterface

>>> design/keyed_table_insert_lookup_delete.sv
// top level: row of table slots, entry count and registered response word
//
// Keyed table of up to 16 key/value pairs kept in insertion order.
// req_i carries one word per action: action (add, lookup, edit, delete,
// clear), key and value. rsp_o returns exactly one word per request:
// status (ok, full, not found), value_out (lookup hit, else zero),
// entry_count and is_empty after the action.
// Every slot compares the key in the same cycle and a first-match chain
// runs through the row; delete shifts each later slot down from its right
// neighbor in that same cycle.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while rsp_o is drained each cycle.
// The single response register sets that figure: req_i.ready is high when
// it is empty or being read in the same cycle.
// Reset empties the table and the response register; slot contents are
// not cleared, only the entry count.
// When the receiver stalls, the response word holds and req_i.ready drops
// until it is taken.
`include "assert_macros.svh"

module keyed_table_insert_lookup_delete (
  input  logic      clk_i,
  input  logic      rst_ni,
  kti_req_if.sink   req_i,
  kti_rsp_if.source rsp_o
);
  import kti_pkg::*;

  cell_ctrl_t            ctrl;
  logic                  accept;
  action_e               action;
  logic [CAPACITY:0]     hit;
  logic [KEY_BITS-1:0]   key_row   [CAPACITY+1];
  logic [VALUE_BITS-1:0] value_row [CAPACITY+1];
  logic [VALUE_BITS-1:0] sel_row   [CAPACITY];
  logic [VALUE_BITS-1:0] found_value;
  logic                  found;

  logic                  rsp_valid_q;
  logic [CNT_W-1:0]      count_q, count_d;
  status_e               status_q, status_d;
  logic [VALUE_BITS-1:0] value_out_q, value_out_d;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign action      = action_e'(req_i.action);

  always_comb begin
    ctrl.go     = accept;
    ctrl.action = action;
    ctrl.key    = req_i.key[KEY_BITS-1:0];
    ctrl.value  = req_i.value[VALUE_BITS-1:0];
    ctrl.count  = count_q;
  end

  assign hit[0] = 1'b0;
  // the slot past the end feeds the last one; it only lands beyond the count
  assign key_row[CAPACITY]   = key_row[CAPACITY-1];
  assign value_row[CAPACITY] = value_row[CAPACITY-1];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kti_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .idx_i       (IDX_W'(i)),
      .hit_i       (hit[i]),
      .next_key_i  (key_row[i+1]),
      .next_value_i(value_row[i+1]),
      .hit_o       (hit[i+1]),
      .key_o       (key_row[i]),
      .value_o     (value_row[i]),
      .sel_value_o (sel_row[i])
    );
  end

  assign found = hit[CAPACITY];

  always_comb begin
    found_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_value = found_value | sel_row[i];
    end
  end

  always_comb begin
    status_d    = ST_OK;
    value_out_d = '0;
    count_d     = count_q;
    unique case (action)
      ACT_ADD: begin
        if (count_q < CNT_W'(CAPACITY)) begin
          count_d = count_q + CNT_W'(1);
        end else begin
          status_d = ST_FULL;
        end
      end
      ACT_LOOKUP: begin
        if (found) begin
          value_out_d = found_value;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      ACT_EDIT: begin
        if (!found) begin
          status_d = ST_NOT_FOUND;
        end
      end
      ACT_DELETE: begin
        if (found) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (accept) begin
        rsp_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      value_out_q <= value_out_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.value_out   = VALUE_W'(value_out_q);
  assign rsp_o.entry_count = COUNT_W'(count_q);
  assign rsp_o.is_empty    = (count_q == '0);

  `KTI_ASSERT_HOLD(a_count_in_range, count_q <= CNT_W'(CAPACITY), "entry count over capacity")
  `KTI_ASSERT(a_count_only_on_word, !accept |=> $stable(count_q), "count moved without a word")
  `KTI_ASSERT(a_full_add,
    (accept && action == ACT_ADD && count_q == CNT_W'(CAPACITY)) |=>
    (status_q == ST_FULL && $stable(count_q)),
    "add on full table not rejected")
  `KTI_ASSERT(a_miss_zero,
    (rsp_valid_q && status_q == ST_NOT_FOUND) |-> (value_out_q == '0),
    "miss with nonzero value")

endmodule

>>> design/kti_cell.sv
// one table slot: stored pair, key compare, first-match chain and shift from the next slot
module kti_cell (
  input  logic                           clk_i,
  input  kti_pkg::cell_ctrl_t            ctrl_i,
  input  logic [kti_pkg::IDX_W-1:0]      idx_i,
  input  logic                           hit_i,
  input  logic [kti_pkg::KEY_BITS-1:0]   next_key_i,
  input  logic [kti_pkg::VALUE_BITS-1:0] next_value_i,
  output logic                           hit_o,
  output logic [kti_pkg::KEY_BITS-1:0]   key_o,
  output logic [kti_pkg::VALUE_BITS-1:0] value_o,
  output logic [kti_pkg::VALUE_BITS-1:0] sel_value_o
);
  import kti_pkg::*;

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  occupied;
  logic                  match;
  logic                  first;
  logic                  at_tail;

  always_comb begin
    occupied    = CNT_W'(idx_i) < ctrl_i.count;
    at_tail     = CNT_W'(idx_i) == ctrl_i.count;
    match       = occupied && (key_q == ctrl_i.key);
    first       = match && !hit_i;
    hit_o       = hit_i || match;
    sel_value_o = first ? value_q : '0;
  end

  assign key_o   = key_q;
  assign value_o = value_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.go) begin
      case (ctrl_i.action)
        ACT_ADD: begin
          if (at_tail) begin
            key_q   <= ctrl_i.key;
            value_q <= ctrl_i.value;
          end
        end
        ACT_EDIT: begin
          if (first) begin
            value_q <= ctrl_i.value;
          end
        end
        ACT_DELETE: begin
          // every slot from the first match on takes its right neighbor
          if (hit_o) begin
            key_q   <= next_key_i;
            value_q <= next_value_i;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
